// ----- hdl/kmr_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmr_pkg
// Shared constants, types, character decode and the sequencer control store
// for the Morse character keyer.
// ----------------------------------------------------------------------------
package kmr_pkg;

  localparam int unsigned SpeedW   = 6;
  localparam int unsigned CharW    = 8;
  localparam int unsigned DurW     = 11;
  localparam int unsigned DivW     = 13;
  localparam int unsigned SymW     = 6;
  localparam int unsigned LenW     = 3;
  localparam int unsigned StepW    = 3;

  localparam int unsigned UnitScale    = 1050;
  localparam int unsigned DitUnits     = 1;
  localparam int unsigned DahUnits     = 3;
  localparam int unsigned WordGapUnits = 7;

  localparam logic [SpeedW-1:0] SpeedReset  = SpeedW'(16);
  localparam logic [SpeedW-1:0] MinDivisor  = SpeedW'(5);
  localparam logic [DivW-1:0]   DitDividend  = DivW'(UnitScale * DitUnits);
  localparam logic [DivW-1:0]   DahDividend  = DivW'(UnitScale * DahUnits);
  localparam logic [DivW-1:0]   WordDividend = DivW'(UnitScale * WordGapUnits);

  // Sequencer steps
  localparam logic [StepW-1:0] STEP_WAIT  = 3'd0;
  localparam logic [StepW-1:0] STEP_SORT  = 3'd1;
  localparam logic [StepW-1:0] STEP_WGAP  = 3'd2;
  localparam logic [StepW-1:0] STEP_TEST  = 3'd3;
  localparam logic [StepW-1:0] STEP_MARK  = 3'd4;
  localparam logic [StepW-1:0] STEP_SPACE = 3'd5;
  localparam logic [StepW-1:0] STEP_CGAP  = 3'd6;

  // Jump conditions
  localparam logic [1:0] COND_ALWAYS = 2'd0;
  localparam logic [1:0] COND_ACCEPT = 2'd1;
  localparam logic [1:0] COND_SPACE  = 2'd2;
  localparam logic [1:0] COND_MORE   = 2'd3;

  // Duration selects
  localparam logic [1:0] DSEL_DIT  = 2'd0;
  localparam logic [1:0] DSEL_DAH  = 2'd1;
  localparam logic [1:0] DSEL_WORD = 2'd2;
  localparam logic [1:0] DSEL_SYM  = 2'd3;

  typedef struct packed {
    logic [DurW-1:0] dit;
    logic [DurW-1:0] dah;
    logic [DurW-1:0] word;
  } spans_t;

  typedef struct packed {
    logic [LenW-1:0] len;
    logic [SymW-1:0] code;   // left aligned, dah = 1, first symbol at the top bit
  } pat_t;

  typedef struct packed {
    logic             emit;
    logic             key;
    logic [1:0]       dsel;
    logic             last;
    logic             shift;
    logic [1:0]       cond;
    logic [StepW-1:0] target;
    logic [StepW-1:0] fall;
  } uword_t;

  function automatic uword_t uw(input logic emit, input logic key, input logic [1:0] dsel,
                                input logic last, input logic shift, input logic [1:0] cond,
                                input logic [StepW-1:0] target,
                                input logic [StepW-1:0] fall);
    uword_t w;
    w.emit   = emit;
    w.key    = key;
    w.dsel   = dsel;
    w.last   = last;
    w.shift  = shift;
    w.cond   = cond;
    w.target = target;
    w.fall   = fall;
    return w;
  endfunction

  // Control store: one word per step
  function automatic uword_t ucode(input logic [StepW-1:0] step);
    uword_t w;
    unique case (step)
      STEP_WAIT:  w = uw(1'b0, 1'b0, DSEL_DIT,  1'b0, 1'b0, COND_ACCEPT, STEP_SORT,
                         STEP_WAIT);
      STEP_SORT:  w = uw(1'b0, 1'b0, DSEL_DIT,  1'b0, 1'b0, COND_SPACE,  STEP_WGAP,
                         STEP_TEST);
      STEP_WGAP:  w = uw(1'b1, 1'b0, DSEL_WORD, 1'b0, 1'b0, COND_ALWAYS, STEP_CGAP,
                         STEP_CGAP);
      STEP_TEST:  w = uw(1'b0, 1'b0, DSEL_DIT,  1'b0, 1'b0, COND_MORE,   STEP_MARK,
                         STEP_CGAP);
      STEP_MARK:  w = uw(1'b1, 1'b1, DSEL_SYM,  1'b0, 1'b1, COND_ALWAYS, STEP_SPACE,
                         STEP_SPACE);
      STEP_SPACE: w = uw(1'b1, 1'b0, DSEL_DIT,  1'b0, 1'b0, COND_MORE,   STEP_MARK,
                         STEP_CGAP);
      STEP_CGAP:  w = uw(1'b1, 1'b0, DSEL_DAH,  1'b1, 1'b0, COND_ALWAYS, STEP_WAIT,
                         STEP_WAIT);
      default:    w = uw(1'b0, 1'b0, DSEL_DIT,  1'b0, 1'b0, COND_ALWAYS, STEP_WAIT,
                         STEP_WAIT);
    endcase
    return w;
  endfunction

  function automatic logic is_gap_char(input logic [CharW-1:0] c);
    return (c == 8'h20) || (c == 8'h5F) || ((c >= 8'h09) && (c <= 8'h0D));
  endfunction

  function automatic pat_t pattern_for(input logic [CharW-1:0] c);
    logic [CharW-1:0] u;
    pat_t p;
    // fold lower case onto upper case
    u = ((c >= 8'h61) && (c <= 8'h7A)) ? (c - 8'h20) : c;
    unique case (u)
      8'h41: p = '{len: 3'd2, code: 6'b010000};  // A
      8'h42: p = '{len: 3'd4, code: 6'b100000};  // B
      8'h43: p = '{len: 3'd4, code: 6'b101000};  // C
      8'h44: p = '{len: 3'd3, code: 6'b100000};  // D
      8'h45: p = '{len: 3'd1, code: 6'b000000};  // E
      8'h46: p = '{len: 3'd4, code: 6'b001000};  // F
      8'h47: p = '{len: 3'd3, code: 6'b110000};  // G
      8'h48: p = '{len: 3'd4, code: 6'b000000};  // H
      8'h49: p = '{len: 3'd2, code: 6'b000000};  // I
      8'h4A: p = '{len: 3'd4, code: 6'b011100};  // J
      8'h4B: p = '{len: 3'd3, code: 6'b101000};  // K
      8'h4C: p = '{len: 3'd4, code: 6'b010000};  // L
      8'h4D: p = '{len: 3'd2, code: 6'b110000};  // M
      8'h4E: p = '{len: 3'd2, code: 6'b100000};  // N
      8'h4F: p = '{len: 3'd3, code: 6'b111000};  // O
      8'h50: p = '{len: 3'd4, code: 6'b011000};  // P
      8'h51: p = '{len: 3'd4, code: 6'b110100};  // Q
      8'h52: p = '{len: 3'd3, code: 6'b010000};  // R
      8'h53: p = '{len: 3'd3, code: 6'b000000};  // S
      8'h54: p = '{len: 3'd1, code: 6'b100000};  // T
      8'h55: p = '{len: 3'd3, code: 6'b001000};  // U
      8'h56: p = '{len: 3'd4, code: 6'b000100};  // V
      8'h57: p = '{len: 3'd3, code: 6'b011000};  // W
      8'h58: p = '{len: 3'd4, code: 6'b100100};  // X
      8'h59: p = '{len: 3'd4, code: 6'b101100};  // Y
      8'h5A: p = '{len: 3'd4, code: 6'b110000};  // Z
      8'h30: p = '{len: 3'd5, code: 6'b111110};  // 0
      8'h31: p = '{len: 3'd5, code: 6'b011110};  // 1
      8'h32: p = '{len: 3'd5, code: 6'b001110};  // 2
      8'h33: p = '{len: 3'd5, code: 6'b000110};  // 3
      8'h34: p = '{len: 3'd5, code: 6'b000010};  // 4
      8'h35: p = '{len: 3'd5, code: 6'b000000};  // 5
      8'h36: p = '{len: 3'd5, code: 6'b100000};  // 6
      8'h37: p = '{len: 3'd5, code: 6'b110000};  // 7
      8'h38: p = '{len: 3'd5, code: 6'b111000};  // 8
      8'h39: p = '{len: 3'd5, code: 6'b111100};  // 9
      8'h2F: p = '{len: 3'd5, code: 6'b100100};  // slash
      8'h3F: p = '{len: 3'd6, code: 6'b001100};  // question mark
      default: p = '{len: 3'd0, code: 6'b000000};
    endcase
    return p;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/kmr_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmr_if
// Valid/ready channels of the keyer: character in, segment out, speed write.
// ----------------------------------------------------------------------------
interface kmr_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

interface kmr_seg_if;
  logic        valid;
  logic        ready;
  logic        key_down;
  logic [10:0] duration_ms;
  logic        last;
  modport source (output valid, output key_down, output duration_ms, output last,
                  input ready);
  modport sink   (input valid, input key_down, input duration_ms, input last,
                  output ready);
endinterface

interface kmr_cfg_if;
  logic       valid;
  logic       ready;
  logic [5:0] speed_wpm;
  modport source (output valid, output speed_wpm, input ready);
  modport sink   (input valid, input speed_wpm, output ready);
endinterface
`default_nettype wire

// ----- hdl/kmr_span_div.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmr_span_div
// Restoring divider, one quotient bit per cycle, that works out the dit,
// dah and word gap durations for the current speed after reset or a write.
// ----------------------------------------------------------------------------
module kmr_span_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [kmr_pkg::SpeedW-1:0]    speed,
  output kmr_pkg::spans_t               spans,
  output logic                          busy
);
  import kmr_pkg::*;

  localparam logic [1:0] JOB_DIT  = 2'd0;
  localparam logic [1:0] JOB_DAH  = 2'd1;
  localparam logic [1:0] JOB_WORD = 2'd2;
  localparam logic [3:0] LastBit  = 4'(DivW - 1);

  logic [1:0]        job;
  logic [3:0]        bit_cnt;
  logic [SpeedW-1:0] rem;
  logic [DivW-1:0]   acc;
  logic [SpeedW-1:0] divisor;
  logic [SpeedW:0]   rem_sh;
  logic [SpeedW:0]   rem_diff;
  logic              ge;
  logic [DivW-1:0]   quo;
  logic [DivW-1:0]   next_dividend;

  // slow speeds clamp to the minimum divisor
  assign divisor  = (speed < MinDivisor) ? MinDivisor : speed;
  assign rem_sh   = {rem, acc[DivW-1]};
  assign ge       = rem_sh >= {1'b0, divisor};
  assign rem_diff = rem_sh - {1'b0, divisor};
  assign quo      = {acc[DivW-2:0], ge};

  always_comb begin
    unique case (job)
      JOB_DIT: next_dividend = DahDividend;
      default: next_dividend = WordDividend;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || start) begin
      busy    <= 1'b1;
      job     <= JOB_DIT;
      bit_cnt <= '0;
      rem     <= '0;
      acc     <= DitDividend;
    end else if (busy) begin
      rem <= ge ? rem_diff[SpeedW-1:0] : rem_sh[SpeedW-1:0];
      acc <= quo;
      if (bit_cnt == LastBit) begin
        bit_cnt <= '0;
        unique case (job)
          JOB_DIT:  spans.dit  <= quo[DurW-1:0];
          JOB_DAH:  spans.dah  <= quo[DurW-1:0];
          default:  spans.word <= quo[DurW-1:0];
        endcase
        if (job == JOB_WORD) begin
          busy <= 1'b0;
        end else begin
          job <= job + 2'd1;
          acc <= next_dividend;
          rem <= '0;
        end
      end else begin
        bit_cnt <= bit_cnt + 4'd1;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/kmr_sequencer.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmr_sequencer
// Step counter over the control store; latches the character pattern and
// drives the registered segment output.
// ----------------------------------------------------------------------------
module kmr_sequencer (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  kmr_pkg::spans_t spans,
  kmr_char_if.sink        char_in,
  kmr_seg_if.source       seg_out
);
  import kmr_pkg::*;

  logic [StepW-1:0] step;
  logic [StepW-1:0] step_next;
  uword_t           ctl;
  logic [SymW-1:0]  sym;
  logic [LenW-1:0]  cnt;
  logic             gap;
  pat_t             pat;
  logic             in_beat;
  logic             slot_free;
  logic             adv;
  logic             cond_hit;
  logic [DurW-1:0]  dur;

  logic             out_valid;
  logic             out_key;
  logic [DurW-1:0]  out_dur;
  logic             out_last;

  assign ctl       = ucode(step);
  assign pat       = pattern_for(char_in.char_code);
  assign char_in.ready = (step == STEP_WAIT) && go;
  assign in_beat   = char_in.valid && char_in.ready;
  assign slot_free = !out_valid || seg_out.ready;
  // hold on an emitting step until the output slot frees
  assign adv       = !ctl.emit || slot_free;

  always_comb begin
    unique case (ctl.cond)
      COND_ALWAYS: cond_hit = 1'b1;
      COND_ACCEPT: cond_hit = in_beat;
      COND_SPACE:  cond_hit = gap;
      COND_MORE:   cond_hit = (cnt != '0);
    endcase
  end

  always_comb begin
    unique case (ctl.dsel)
      DSEL_DIT:  dur = spans.dit;
      DSEL_DAH:  dur = spans.dah;
      DSEL_WORD: dur = spans.word;
      DSEL_SYM:  dur = sym[SymW-1] ? spans.dah : spans.dit;
    endcase
  end

  assign step_next = adv ? (cond_hit ? ctl.target : ctl.fall) : step;

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_WAIT;
      out_valid <= 1'b0;
    end else begin
      step <= step_next;
      if (ctl.emit && slot_free) begin
        out_valid <= 1'b1;
      end else if (seg_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      sym <= pat.code;
      cnt <= pat.len;
      gap <= is_gap_char(char_in.char_code);
    end else if (adv && ctl.shift) begin
      sym <= {sym[SymW-2:0], 1'b0};
      cnt <= cnt - 3'd1;
    end
    if (ctl.emit && slot_free) begin
      out_key  <= ctl.key;
      out_dur  <= dur;
      out_last <= ctl.last;
    end
  end

  assign seg_out.valid       = out_valid;
  assign seg_out.key_down    = out_key;
  assign seg_out.duration_ms = out_dur;
  assign seg_out.last        = out_last;

endmodule
`default_nettype wire

// ----- hdl/morse_character_keyer_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// morse_character_keyer_top
// Turns one character per beat into timed key-down and key-up segments.
// ----------------------------------------------------------------------------
//  channel   dir  payload                          beat
//  cfg       in   speed_wpm[5:0]                   valid & ready (ready held high)
//  char_in   in   char_code[7:0]                   valid & ready
//  seg_out   out  key_down, duration_ms[10:0], last valid & ready
//
//  A character runs accept, sort and test, then one step per segment; a word
//  gap character skips the test. The sequencer runs one control word per
//  cycle while seg_out is not stalled.
//  Reset and every speed write start a divider pass (three 13-bit quotients,
//  one bit a cycle); char_in.ready stays low until it ends.
//  A stalled seg_out holds the sequencer on its emitting step.
// ----------------------------------------------------------------------------
module morse_character_keyer_top (
  input  logic      clk,
  input  logic      rst,
  kmr_cfg_if.sink   cfg,
  kmr_char_if.sink  char_in,
  kmr_seg_if.source seg_out
);
  import kmr_pkg::*;

  logic [SpeedW-1:0] speed;
  logic              start;
  logic              busy;
  spans_t            spans;

  assign cfg.ready = 1'b1;
  assign start     = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed <= SpeedReset;
    end else if (start) begin
      speed <= cfg.speed_wpm;
    end
  end

  kmr_span_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .speed (speed),
    .spans (spans),
    .busy  (busy)
  );

  kmr_sequencer u_seq (
    .clk     (clk),
    .rst     (rst),
    .go      (!busy && !cfg.valid),
    .spans   (spans),
    .char_in (char_in),
    .seg_out (seg_out)
  );

endmodule
`default_nettype wire

// ----- hdl/kmr_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// kmr_checker
// Port-level checks on the keyer, bound to the top level.
// ----------------------------------------------------------------------------
module kmr_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        key_down,
  input logic [10:0] duration_ms,
  input logic        last
);

  // a stalled segment holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(key_down) &&
                                $stable(duration_ms) && $stable(last))
    else $error("segment changed while stalled");

  // one character at a time: ready drops after a character beat
  a_one_char: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("character accepted while busy");

  // the closing segment is always key up
  a_last_up: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> !key_down)
    else $error("closing segment keyed down");

  // durations stay in the range the speed allows
  a_dur_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (duration_ms != 11'd0) && (duration_ms <= 11'd1470))
    else $error("segment duration out of range");

endmodule

bind morse_character_keyer_top kmr_checker u_kmr_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (char_in.valid),
  .in_ready    (char_in.ready),
  .out_valid   (seg_out.valid),
  .out_ready   (seg_out.ready),
  .key_down    (seg_out.key_down),
  .duration_ms (seg_out.duration_ms),
  .last        (seg_out.last)
);
`default_nettype wire

// ----- test/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the Morse character keyer. A short table of
// characters and speeds runs first, then random characters over several
// speed settings, with random gaps on the character side and random stalls
// on the segment side. Every segment is checked against a local predictor.
// ----------------------------------------------------------------------------
module tb;
  import kmr_pkg::*;

  localparam int unsigned CharGapUnits = 3;
  localparam int unsigned SettleCycles = 24;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned PhaseItems   = 44;
  localparam int unsigned NumDirected  = 25;
  localparam longint      TimeoutTicks = 64'd15_000_000;

  localparam logic [CharW-1:0] CH_TAB        = 8'h09;
  localparam logic [CharW-1:0] CH_CR         = 8'h0D;
  localparam logic [CharW-1:0] CH_SPACE      = 8'h20;
  localparam logic [CharW-1:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [CharW-1:0] CASE_FOLD     = 8'h20;

  typedef struct packed {
    logic            key_down;
    logic [DurW-1:0] duration_ms;
    logic            last;
  } seg_t;

  // typed rows carry the closing gap of a character that has no code
  typedef struct packed {
    logic [SpeedW-1:0] speed;
    logic [CharW-1:0]  code;
    logic              typed;
    logic [DurW-1:0]   gap_ms;
  } directed_row_t;

  directed_row_t directed_rows [NumDirected] = '{
    '{6'd16, 8'h00, 1'b1, 11'd196},
    '{6'd16, "A",   1'b0, 11'd0},
    '{6'd16, "z",   1'b0, 11'd0},
    '{6'd16, "0",   1'b0, 11'd0},
    '{6'd16, "9",   1'b0, 11'd0},
    '{6'd16, "/",   1'b0, 11'd0},
    '{6'd16, "?",   1'b0, 11'd0},
    '{6'd16, " ",   1'b0, 11'd0},
    '{6'd16, 8'h09, 1'b0, 11'd0},
    '{6'd16, 8'h0D, 1'b0, 11'd0},
    '{6'd16, "_",   1'b0, 11'd0},
    '{6'd16, 8'h08, 1'b1, 11'd196},
    '{6'd16, 8'hFF, 1'b1, 11'd196},
    '{6'd16, "!",   1'b1, 11'd196},
    '{6'd16, "Q",   1'b0, 11'd0},
    '{6'd16, "m",   1'b0, 11'd0},
    '{6'd0,  "?",   1'b0, 11'd0},
    '{6'd0,  " ",   1'b0, 11'd0},
    '{6'd0,  8'h80, 1'b1, 11'd630},
    '{6'd4,  8'h0E, 1'b1, 11'd630},
    '{6'd63, "H",   1'b0, 11'd0},
    '{6'd63, 8'h7F, 1'b1, 11'd50},
    '{6'd60, "5",   1'b0, 11'd0},
    '{6'd60, 8'h60, 1'b1, 11'd52},
    '{6'd60, 8'h5B, 1'b1, 11'd52}
  };

  logic clk;
  logic rst;

  kmr_cfg_if  cfg_bus ();
  kmr_char_if char_bus ();
  kmr_seg_if  seg_bus ();

  morse_character_keyer_top DUT (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_bus),
    .char_in (char_bus),
    .seg_out (seg_bus)
  );

  logic [SpeedW-1:0] speed_setting;
  seg_t              pending_segs [$];
  int unsigned       mismatches;
  bit                steady_send;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic logic [DurW-1:0] span_ms(input int unsigned units);
    int unsigned w;
    w = (speed_setting < MinDivisor) ? MinDivisor : speed_setting;
    return DurW'((UnitScale * units) / w);
  endfunction

  function automatic bit is_word_gap(input logic [CharW-1:0] c);
    return (c == CH_SPACE) || (c == CH_UNDERSCORE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic string marks_for(input logic [CharW-1:0] c);
    logic [CharW-1:0] u;
    u = ((c >= "a") && (c <= "z")) ? (c - CASE_FOLD) : c;
    case (u)
      "A": return ".-";
      "B": return "-...";
      "C": return "-.-.";
      "D": return "-..";
      "E": return ".";
      "F": return "..-.";
      "G": return "--.";
      "H": return "....";
      "I": return "..";
      "J": return ".---";
      "K": return "-.-";
      "L": return ".-..";
      "M": return "--";
      "N": return "-.";
      "O": return "---";
      "P": return ".--.";
      "Q": return "--.-";
      "R": return ".-.";
      "S": return "...";
      "T": return "-";
      "U": return "..-";
      "V": return "...-";
      "W": return ".--";
      "X": return "-..-";
      "Y": return "-.--";
      "Z": return "--..";
      "0": return "-----";
      "1": return ".----";
      "2": return "..---";
      "3": return "...--";
      "4": return "....-";
      "5": return ".....";
      "6": return "-....";
      "7": return "--...";
      "8": return "---..";
      "9": return "----.";
      "/": return "-..-.";
      "?": return "..--..";
      default: return "";
    endcase
  endfunction

  task automatic push_segments(input logic [CharW-1:0] c);
    string marks;
    int    i;
    if (is_word_gap(c))
      pending_segs.push_back('{1'b0, span_ms(WordGapUnits), 1'b0});
    marks = marks_for(c);
    for (i = 0; i < marks.len(); i++) begin
      pending_segs.push_back('{1'b1, span_ms((marks[i] == "-") ? DahUnits : DitUnits), 1'b0});
      pending_segs.push_back('{1'b0, span_ms(DitUnits), 1'b0});
    end
    pending_segs.push_back('{1'b0, span_ms(CharGapUnits), 1'b1});
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk) begin : seg_check
    seg_t want;
    if (!rst && seg_bus.valid && seg_bus.ready) begin
      if (pending_segs.size() == 0) begin
        report_mismatch("segment beat with nothing pending");
      end else begin
        want = pending_segs.pop_front();
        if (seg_bus.key_down !== want.key_down)
          report_mismatch($sformatf("key_down %0b, want %0b", seg_bus.key_down, want.key_down));
        if (seg_bus.duration_ms !== want.duration_ms)
          report_mismatch($sformatf("duration_ms %0d, want %0d", seg_bus.duration_ms,
                                    want.duration_ms));
        if (seg_bus.last !== want.last)
          report_mismatch($sformatf("last %0b, want %0b", seg_bus.last, want.last));
      end
    end
  end

  // ---------------------------------------------------------------- segment side

  initial begin : seg_stall
    int unsigned burst;
    int unsigned stall;
    int unsigned r;
    seg_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      burst = (r < 10) ? $urandom_range(50, 200) : $urandom_range(1, 8);
      seg_bus.ready <= 1'b1;
      repeat (burst) @(negedge clk);
      r = $urandom_range(0, 99);
      if (r < 50)      stall = $urandom_range(1, 2);
      else if (r < 90) stall = $urandom_range(3, 6);
      else             stall = $urandom_range(20, 60);
      seg_bus.ready <= 1'b0;
      repeat (stall - 1) @(negedge clk);
    end
  end

  // ---------------------------------------------------------------- character side

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (steady_send) return 0;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [CharW-1:0] pick_char();
    int unsigned r;
    int unsigned k;
    r = $urandom_range(0, 99);
    if (r < 30) return CharW'("A" + $urandom_range(0, 25));
    if (r < 45) return CharW'("a" + $urandom_range(0, 25));
    if (r < 57) return CharW'("0" + $urandom_range(0, 9));
    if (r < 60) return ($urandom_range(0, 1) == 0) ? "/" : "?";
    if (r < 72) begin
      k = $urandom_range(0, 6);
      if (k < 5) return CharW'(CH_TAB + k);
      return (k == 5) ? CH_SPACE : CH_UNDERSCORE;
    end
    return CharW'($urandom_range(0, 255));
  endfunction

  // Entered and left at a falling edge.
  task automatic send_char(input logic [CharW-1:0] c, input bit typed,
                           input logic [DurW-1:0] gap_ms);
    int unsigned gap;
    gap = pick_gap();
    if (gap > 0) begin
      char_bus.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    char_bus.valid     <= 1'b1;
    char_bus.char_code <= c;
    do @(posedge clk); while (!char_bus.ready);
    if (typed)
      pending_segs.push_back('{1'b0, gap_ms, 1'b1});
    else
      push_segments(c);
    @(negedge clk);
  endtask

  // Hold off until every pending segment has arrived and the sequencer is back.
  task automatic drain_segments();
    char_bus.valid <= 1'b0;
    while (pending_segs.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_speed(input logic [SpeedW-1:0] value);
    drain_segments();
    cfg_bus.valid     <= 1'b1;
    cfg_bus.speed_wpm <= value;
    do @(posedge clk); while (!cfg_bus.ready);
    speed_setting = value;
    @(negedge clk);
    cfg_bus.valid <= 1'b0;
  endtask

  function automatic logic [SpeedW-1:0] phase_speed(input int unsigned phase);
    case (phase)
      0: return 6'd63;
      1: return 6'd0;
      2: return 6'd60;
      3: return 6'd5;
      4: return 6'd1;
      default: return SpeedW'($urandom_range(0, 63));
    endcase
  endfunction

  initial begin : stimulus
    int unsigned phase;
    int unsigned n;
    rst                = 1'b1;
    cfg_bus.valid      = 1'b0;
    cfg_bus.speed_wpm  = '0;
    char_bus.valid     = 1'b0;
    char_bus.char_code = '0;
    speed_setting      = SpeedReset;
    mismatches         = 0;
    steady_send        = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (n = 0; n < NumDirected; n++) begin
      if (directed_rows[n].speed != speed_setting)
        write_speed(directed_rows[n].speed);
      send_char(directed_rows[n].code, directed_rows[n].typed, directed_rows[n].gap_ms);
    end

    for (phase = 0; phase < RandomPhases; phase++) begin
      write_speed(phase_speed(phase));
      steady_send = (phase % 3 == 2);
      for (n = 0; n < PhaseItems; n++) begin
        if (n == 24 || $urandom_range(0, 49) == 0)
          drain_segments();
        send_char(pick_char(), 1'b0, '0);
      end
    end

    drain_segments();
    if (mismatches == 0)
      $display("tb OK");
    else
      $display("tb NOT OK");
    $finish;
  end

  initial begin : watchdog
    #(TimeoutTicks);
    $display("tb NOT OK");
    $finish;
  end

endmodule
